// File: rtl/psl_pkg.sv
`timescale 1ns / 1ps

package psl_pkg;

    localparam int PSL_MAX_TOKEN_LEN = 40;
    localparam int NKW = 19;

    // Result kinds.
    localparam logic [1:0] KIND_TEXT      = 2'd0;
    localparam logic [1:0] KIND_END       = 2'd1;
    localparam logic [1:0] KIND_INPUT_END = 2'd2;

    // Token classes.
    localparam logic [4:0] CL_IDENT   = 5'd0;
    localparam logic [4:0] CL_KEYWORD = 5'd1;
    localparam logic [4:0] CL_LPAR    = 5'd2;
    localparam logic [4:0] CL_RPAR    = 5'd3;
    localparam logic [4:0] CL_PLUS    = 5'd4;
    localparam logic [4:0] CL_MINUS   = 5'd5;
    localparam logic [4:0] CL_STAR    = 5'd6;
    localparam logic [4:0] CL_SLASH   = 5'd7;
    localparam logic [4:0] CL_EQ      = 5'd8;
    localparam logic [4:0] CL_SEMI    = 5'd9;
    localparam logic [4:0] CL_DOT     = 5'd10;
    localparam logic [4:0] CL_COMMA   = 5'd11;
    localparam logic [4:0] CL_GT      = 5'd12;
    localparam logic [4:0] CL_GE      = 5'd13;
    localparam logic [4:0] CL_LT      = 5'd14;
    localparam logic [4:0] CL_LE      = 5'd15;
    localparam logic [4:0] CL_NE      = 5'd16;
    localparam logic [4:0] CL_COLON   = 5'd17;
    localparam logic [4:0] CL_ASSIGN  = 5'd18;
    localparam logic [4:0] CL_INT     = 5'd19;
    localparam logic [4:0] CL_REAL    = 5'd20;
    localparam logic [4:0] CL_STRING  = 5'd21;
    localparam logic [4:0] CL_ERROR   = 5'd22;

    localparam logic [3:0] SCAN_START_CODE = 4'd0;

    typedef struct packed {
        logic [3:0]     state;
        logic [5:0]     len;
        logic [4:0]     cls;
        logic [NKW-1:0] cand;
    } t_scan_st;

    localparam t_scan_st SCAN_RESET = '{
        state: SCAN_START_CODE, len: 6'd0, cls: CL_ERROR, cand: {NKW{1'b1}}
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [4:0] cls;
        logic [5:0] len;
    } t_res;

    typedef struct packed {
        t_scan_st   next_st;
        t_res [1:0] res;
        logic [1:0] n;
        logic       again;
    } t_scan_out;

    // Keyword spellings. Each string is written reversed so that the first
    // character of the keyword sits in the low byte of the word.
    localparam logic [63:0] KW_TEXT [NKW] = '{
        64'("nigeb"), 64'("naeloob"), 64'("rahc"), 64'("od"), 64'("esle"),
        64'("dne"), 64'("eslaf"), 64'("rof"), 64'("fi"), 64'("regetni"),
        64'("margorp"), 64'("laer"), 64'("taeper"), 64'("neht"), 64'("ot"),
        64'("eurt"), 64'("litnu"), 64'("rav"), 64'("elihw")
    };

    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd5, 4'd7, 4'd4, 4'd2, 4'd4, 4'd3, 4'd5, 4'd3, 4'd2, 4'd7,
        4'd7, 4'd4, 4'd6, 4'd4, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5
    };

endpackage

// File: rtl/psl_scan.sv
`timescale 1ns / 1ps

module psl_scan import psl_pkg::*; #(
    parameter int MAX_TOKEN_LEN = PSL_MAX_TOKEN_LEN
) (
    input  t_scan_st  i_st,
    input  logic [7:0] i_char,
    output t_scan_out o_out
);

    localparam logic [5:0] MAX_LEN = 6'(MAX_TOKEN_LEN);

    typedef enum logic [3:0] {
        ST_START   = SCAN_START_CODE,
        ST_IDENT   = 4'd1,
        ST_PAREN   = 4'd2,
        ST_COMMENT = 4'd3,
        ST_COMSTAR = 4'd4,
        ST_GT      = 4'd5,
        ST_LT      = 4'd6,
        ST_COLON   = 4'd7,
        ST_INT     = 4'd8,
        ST_REAL    = 4'd9,
        ST_STR     = 4'd10,
        ST_QUOTE   = 4'd11
    } t_state;

    t_state         cur;
    t_state         nxt;
    logic           do_put;
    logic [7:0]     put_ch;
    logic [7:0]     lc;
    logic           cls_set;
    logic [4:0]     cls_val;
    logic           do_fin;
    logic           again;
    logic           fin;
    logic [NKW-1:0] cand1;
    logic [5:0]     len1;
    logic [4:0]     cls1;
    logic           kw_hit;
    logic [4:0]     fin_cls;
    logic           is_letter;
    logic           is_digit;
    logic           is_space;
    t_res           text_res;
    t_res           end_res;

    assign cur       = t_state'(i_st.state);
    assign is_letter = (i_char inside {["a":"z"], ["A":"Z"]});
    assign is_digit  = (i_char inside {["0":"9"]});
    assign is_space  = (i_char == " ") || (i_char inside {[8'd9:8'd13]});

    // Decide what this character does to the scanner.
    always_comb begin
        do_put  = 1'b0;
        put_ch  = i_char;
        cls_set = 1'b0;
        cls_val = i_st.cls;
        do_fin  = 1'b0;
        again   = 1'b0;
        nxt     = cur;
        case (cur)
            ST_IDENT: begin
                if (is_letter || is_digit || i_char == "_") begin
                    do_put = 1'b1;
                end else begin
                    do_fin = 1'b1;
                    again  = 1'b1;
                end
            end
            ST_PAREN: begin
                if (i_char == "*") begin
                    nxt = ST_COMMENT;
                end else begin
                    do_put  = 1'b1;
                    put_ch  = "(";
                    cls_set = 1'b1;
                    cls_val = CL_LPAR;
                    do_fin  = 1'b1;
                    again   = 1'b1;
                end
            end
            ST_COMMENT: begin
                if (i_char == "*") nxt = ST_COMSTAR;
            end
            ST_COMSTAR: begin
                if (i_char == ")") nxt = ST_START;
                else if (i_char != "*") nxt = ST_COMMENT;
            end
            ST_GT: begin
                cls_set = 1'b1;
                do_fin  = 1'b1;
                if (i_char == "=") begin
                    do_put  = 1'b1;
                    cls_val = CL_GE;
                end else begin
                    cls_val = CL_GT;
                    again   = 1'b1;
                end
            end
            ST_LT: begin
                cls_set = 1'b1;
                do_fin  = 1'b1;
                if (i_char == "=") begin
                    do_put  = 1'b1;
                    cls_val = CL_LE;
                end else if (i_char == ">") begin
                    do_put  = 1'b1;
                    cls_val = CL_NE;
                end else begin
                    cls_val = CL_LT;
                    again   = 1'b1;
                end
            end
            ST_COLON: begin
                cls_set = 1'b1;
                do_fin  = 1'b1;
                if (i_char == "=") begin
                    do_put  = 1'b1;
                    cls_val = CL_ASSIGN;
                end else begin
                    cls_val = CL_COLON;
                    again   = 1'b1;
                end
            end
            ST_INT: begin
                if (is_digit) begin
                    do_put = 1'b1;
                end else if (i_char == ".") begin
                    do_put = 1'b1;
                    nxt    = ST_REAL;
                end else begin
                    cls_set = 1'b1;
                    cls_val = CL_INT;
                    do_fin  = 1'b1;
                    again   = 1'b1;
                end
            end
            ST_REAL: begin
                if (is_digit) begin
                    do_put = 1'b1;
                end else begin
                    cls_set = 1'b1;
                    cls_val = CL_REAL;
                    do_fin  = 1'b1;
                    again   = 1'b1;
                end
            end
            ST_STR: begin
                if (i_char == "'") nxt = ST_QUOTE;
                else do_put = 1'b1;
            end
            ST_QUOTE: begin
                if (i_char == "'") begin
                    do_put = 1'b1;
                    nxt    = ST_STR;
                end else begin
                    cls_set = 1'b1;
                    cls_val = CL_STRING;
                    do_fin  = 1'b1;
                    again   = 1'b1;
                end
            end
            default: begin
                // Start state; unused codes behave the same way.
                nxt = ST_START;
                if (is_letter || i_char == "_") begin
                    do_put  = 1'b1;
                    cls_set = 1'b1;
                    cls_val = CL_IDENT;
                    nxt     = ST_IDENT;
                end else if (is_space) begin
                    nxt = ST_START;
                end else if (is_digit) begin
                    do_put  = 1'b1;
                    cls_set = 1'b1;
                    cls_val = CL_INT;
                    nxt     = ST_INT;
                end else begin
                    case (i_char)
                        "+": begin do_put = 1'b1; cls_set = 1'b1; cls_val = CL_PLUS;  do_fin = 1'b1; end
                        "-": begin do_put = 1'b1; cls_set = 1'b1; cls_val = CL_MINUS; do_fin = 1'b1; end
                        "*": begin do_put = 1'b1; cls_set = 1'b1; cls_val = CL_STAR;  do_fin = 1'b1; end
                        "/": begin do_put = 1'b1; cls_set = 1'b1; cls_val = CL_SLASH; do_fin = 1'b1; end
                        "=": begin do_put = 1'b1; cls_set = 1'b1; cls_val = CL_EQ;    do_fin = 1'b1; end
                        ";": begin do_put = 1'b1; cls_set = 1'b1; cls_val = CL_SEMI;  do_fin = 1'b1; end
                        ".": begin do_put = 1'b1; cls_set = 1'b1; cls_val = CL_DOT;   do_fin = 1'b1; end
                        ",": begin do_put = 1'b1; cls_set = 1'b1; cls_val = CL_COMMA; do_fin = 1'b1; end
                        ")": begin do_put = 1'b1; cls_set = 1'b1; cls_val = CL_RPAR;  do_fin = 1'b1; end
                        "(": nxt = ST_PAREN;
                        ">": begin do_put = 1'b1; nxt = ST_GT; end
                        "<": begin do_put = 1'b1; nxt = ST_LT; end
                        ":": begin do_put = 1'b1; nxt = ST_COLON; end
                        "'": nxt = ST_STR;
                        default: begin
                            do_put  = 1'b1;
                            cls_set = 1'b1;
                            cls_val = CL_ERROR;
                            do_fin  = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    // Apply the stored character: narrow the keyword candidates and count it.
    assign lc = (put_ch inside {["A":"Z"]}) ? put_ch + 8'd32 : put_ch;

    always_comb begin
        cand1 = i_st.cand;
        if (do_put) begin
            for (int k = 0; k < NKW; k++) begin
                cand1[k] = i_st.cand[k] && (i_st.len < {2'b00, KW_LEN[k]})
                           && (KW_TEXT[k][{i_st.len[2:0], 3'b000} +: 8] == lc);
            end
        end
    end

    assign len1 = do_put ? i_st.len + 6'd1 : i_st.len;
    assign cls1 = cls_set ? cls_val : i_st.cls;
    assign fin  = do_fin || (len1 >= MAX_LEN);

    always_comb begin
        kw_hit = 1'b0;
        for (int k = 0; k < NKW; k++) begin
            if (cand1[k] && ({2'b00, KW_LEN[k]} == len1)) kw_hit = 1'b1;
        end
    end

    assign fin_cls  = (cls1 == CL_IDENT && kw_hit) ? CL_KEYWORD : cls1;
    assign text_res = '{kind: KIND_TEXT, ch: put_ch, cls: 5'd0, len: 6'd0};
    assign end_res  = '{kind: KIND_END, ch: 8'd0, cls: fin_cls, len: len1};

    always_comb begin
        o_out.again = again;
        if (do_put) begin
            o_out.res[0] = text_res;
            o_out.res[1] = end_res;
            o_out.n      = fin ? 2'd2 : 2'd1;
        end else begin
            o_out.res[0] = end_res;
            o_out.res[1] = end_res;
            o_out.n      = fin ? 2'd1 : 2'd0;
        end
        if (fin) begin
            o_out.next_st = SCAN_RESET;
        end else begin
            o_out.next_st = '{state: nxt, len: len1, cls: cls1, cand: cand1};
        end
    end

endmodule

// File: rtl/pascal_subset_lexer.sv
`timescale 1ns / 1ps
// Lexical scanner for a small Pascal-like language, one source byte per
// input transaction. The input channel (i_valid / o_stall) carries a byte on
// i_input_char, or an end-of-source mark on i_end_of_input. The output channel
// (o_valid / i_stall) carries one result per transaction: a token text
// character, a token end with class and length, or an input-ended mark.
// o_last_of_run flags the final result that a given input byte caused.
// An accepted byte waits in the input register, where the scanner logic
// runs, until the result buffer can take its results. Throughput: one byte
// per cycle while each byte gives at most one result and the receiver does
// not stall. A byte that gives n results (up to four) occupies the result
// buffer while its results leave one per cycle; the input register then
// holds the following byte and o_stall is raised until the buffer drains.
// When the receiver stalls, the presented result holds and the buffer does
// not advance; once the input register is also full, o_stall goes high.
// Reset (synchronous, active low) empties the input register and the result
// buffer and returns the scanner to its start state with no pending token.
module pascal_subset_lexer import psl_pkg::*; #(
    parameter int MAX_TOKEN_LEN = PSL_MAX_TOKEN_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_input_char,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_text_char,
    output logic [4:0] o_token_class,
    output logic [5:0] o_token_length,
    output logic       o_last_of_run
);

    localparam logic [5:0] MAX_LEN = 6'(MAX_TOKEN_LEN);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eoi;

    // Scanner state carried from byte to byte.
    t_scan_st   r_scan;
    t_scan_st   n_scan;

    // Result buffer: the results of one byte, head at entry 0.
    t_res       r_buf [4];
    t_res       n_buf [4];
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    logic       out_take;
    logic       in_consume;
    logic       load;
    t_scan_out  pass1;
    t_scan_out  pass2;
    logic [1:0] n2;

    // The buffer only ever holds results of a single byte, so the next byte
    // may be scanned once the buffer is empty or its last entry leaves now.
    assign out_take   = (r_cnt != 3'd0) && !i_stall;
    assign in_consume = (r_cnt == 3'd0) || (r_cnt == 3'd1 && out_take);
    assign load       = r_in_valid && in_consume;
    assign o_stall    = r_in_valid && !in_consume;

    // A character that ends a token by not belonging to it is scanned a
    // second time from the fresh state that the first pass leaves behind.
    psl_scan #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_scan_first (
        .i_st   (r_scan),
        .i_char (r_in_char),
        .o_out  (pass1)
    );

    psl_scan #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_scan_again (
        .i_st   (pass1.next_st),
        .i_char (r_in_char),
        .o_out  (pass2)
    );

    assign n2 = pass1.again ? pass2.n : 2'd0;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_buf[i] = '0;
        end
        if (r_in_eoi) begin
            // End of source drops any pending token, including a held '('.
            n_buf[0] = '{kind: KIND_INPUT_END, ch: 8'd0, cls: 5'd0, len: 6'd0};
            n_cnt    = 3'd1;
            n_scan   = SCAN_RESET;
        end else begin
            case (pass1.n)
                2'd1: begin
                    n_buf[0] = pass1.res[0];
                    n_buf[1] = pass2.res[0];
                    n_buf[2] = pass2.res[1];
                end
                2'd2: begin
                    n_buf[0] = pass1.res[0];
                    n_buf[1] = pass1.res[1];
                    n_buf[2] = pass2.res[0];
                    n_buf[3] = pass2.res[1];
                end
                default: begin
                    n_buf[0] = pass1.res[0];
                end
            endcase
            n_cnt  = {1'b0, pass1.n} + {1'b0, n2};
            n_scan = pass1.again ? pass2.next_st : pass1.next_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 3'd0;
            r_scan     <= SCAN_RESET;
        end else begin
            if (!o_stall) r_in_valid <= i_valid;
            if (load) begin
                r_cnt  <= n_cnt;
                r_scan <= n_scan;
            end else if (out_take) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_char <= i_input_char;
            r_in_eoi  <= i_end_of_input;
        end
        if (load) begin
            r_buf <= n_buf;
        end else if (out_take) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
            r_buf[2] <= r_buf[3];
        end
    end

    assign o_valid        = (r_cnt != 3'd0);
    assign o_result_kind  = r_buf[0].kind;
    assign o_text_char    = r_buf[0].ch;
    assign o_token_class  = r_buf[0].cls;
    assign o_token_length = r_buf[0].len;
    assign o_last_of_run  = (r_cnt == 3'd1);

    // The buffer never holds more than the four results of one byte.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result buffer count out of range");

    // A stalled receiver freezes the buffer.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (r_cnt == $past(r_cnt)))
        else $error("result buffer moved while output stalled");

    // End of source gives exactly one input-ended result and a clean scanner.
    a_eoi_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_in_eoi) |=> (r_cnt == 3'd1 && o_result_kind == KIND_INPUT_END
                                && r_scan == SCAN_RESET))
        else $error("end of source not handled");

    // No finished token is longer than the length limit.
    a_len_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == KIND_END) |-> (o_token_length <= MAX_LEN))
        else $error("token longer than limit");

endmodule
